// ===== design/signed_binary_to_decimal_ascii_top_macros.svh =====
// Assertion macros shared by the decimal text converter modules.
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sbda_pkg.sv =====
// Shared types and constants for the decimal text converter.
`timescale 1ns / 1ps
package sbda_pkg;

  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  // Double-dabble correction: a BCD digit of 5 or more gets 3 added before a shift.
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== design/signed_binary_to_decimal_ascii_top.sv =====
// Top level of the signed binary to decimal ASCII converter.
//
//   Channel  Ports                                           Handshake
//   request  start, busy, in_value                           taken when start && !busy
//   result   out_strobe, out_character, out_text_length,     one cycle per character,
//            out_last                                        cannot be held off
//
// A conversion runs the double-dabble loop two bits at a time, then emits one character
// per cycle; after the last character, a request already in the queue is loaded at once.
// At 32 bits the text has up to 11 characters, sign included.
// A two-entry queue holds requests, so busy rises only with two requests waiting.
// Reset is synchronous and active low; it empties the queue and drops any text in flight.
`timescale 1ns / 1ps
module signed_binary_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_strobe,
  output logic [5:0]             out_character,
  output logic [3:0]             out_text_length,
  output logic                   out_last
);

  localparam int MAGW = VALUE_WIDTH + (VALUE_WIDTH % 2);

  sbda_pkg::q_stat_t stat;
  logic              push, push_neg, pop, head_neg;
  logic [MAGW-1:0]   push_mag, head_mag;

  sbda_front #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAGW       (MAGW)
  ) u_front (
    .start   (start),
    .busy    (busy),
    .in_value(in_value),
    .stat    (stat),
    .push    (push),
    .push_neg(push_neg),
    .push_mag(push_mag)
  );

  sbda_queue #(
    .MAGW(MAGW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_neg(push_neg),
    .push_mag(push_mag),
    .pop     (pop),
    .head_neg(head_neg),
    .head_mag(head_mag),
    .stat    (stat)
  );

  sbda_back #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAGW       (MAGW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .stat           (stat),
    .q_neg          (head_neg),
    .q_mag          (head_mag),
    .pop            (pop),
    .out_strobe     (out_strobe),
    .out_character  (out_character),
    .out_text_length(out_text_length),
    .out_last       (out_last)
  );

endmodule

// ===== design/sbda_front.sv =====
// Front end: accepts a request, splits it into sign and magnitude.
`timescale 1ns / 1ps
module sbda_front #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAGW        = 32
) (
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  sbda_pkg::q_stat_t      stat,
  output logic                   push,
  output logic                   push_neg,
  output logic [MAGW-1:0]        push_mag
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // The most negative value negates to itself, which read unsigned is its magnitude.
  always_comb begin
    neg = in_value[VALUE_WIDTH-1];
    mag = neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
  end

  assign busy     = stat.full;
  assign push     = start && !stat.full;
  assign push_neg = neg;
  assign push_mag = MAGW'(mag);

endmodule

// ===== design/sbda_queue.sv =====
// Two-entry queue of classified requests between front and back.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_top_macros.svh"
module sbda_queue #(
  parameter int MAGW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic              push_neg,
  input  logic [MAGW-1:0]   push_mag,
  input  logic              pop,
  output logic              head_neg,
  output logic [MAGW-1:0]   head_mag,
  output sbda_pkg::q_stat_t stat
);

  logic [1:0]      cnt_r, cnt_nxt;
  logic            head_neg_r, tail_neg_r;
  logic [MAGW-1:0] head_mag_r, tail_mag_r;
  logic            push_eff, pop_eff;
  logic [1:0]      slot;

  always_comb begin
    pop_eff  = pop && (cnt_r != 2'd0);
    push_eff = push && (cnt_r != 2'd2);
    slot     = cnt_r - {1'b0, pop_eff};
    cnt_nxt  = cnt_r + {1'b0, push_eff} - {1'b0, pop_eff};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    // A request pushed into an emptied head slot takes priority over the shift.
    if (push_eff && (slot == 2'd0)) begin
      head_neg_r <= push_neg;
      head_mag_r <= push_mag;
    end else if (pop_eff) begin
      head_neg_r <= tail_neg_r;
      head_mag_r <= tail_mag_r;
    end
    if (push_eff && (slot != 2'd0)) begin
      tail_neg_r <= push_neg;
      tail_mag_r <= push_mag;
    end
  end

  assign head_neg = head_neg_r;
  assign head_mag = head_mag_r;
  assign stat     = '{full: (cnt_r == 2'd2), empty: (cnt_r == 2'd0)};

  `SBDA_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3, "queue count out of range")
  `SBDA_ASSERT_NEXT(a_full_holds, clk, rst_n, (cnt_r == 2'd2) && !pop, cnt_r == 2'd2,
                    "full queue lost an entry without a pop")
  `SBDA_ASSERT_NEXT(a_push_empty, clk, rst_n, push && !pop && (cnt_r == 2'd0),
                    cnt_r == 2'd1, "push into empty queue was dropped")

endmodule

// ===== design/sbda_back.sv =====
// Back end: double-dabble conversion two bits a cycle, then one character a cycle.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_top_macros.svh"
module sbda_back #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAGW        = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sbda_pkg::q_stat_t stat,
  input  logic              q_neg,
  input  logic [MAGW-1:0]   q_mag,
  output logic              pop,
  output logic              out_strobe,
  output logic [5:0]        out_character,
  output logic [3:0]        out_text_length,
  output logic              out_last
);

  localparam int NDIG  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int DIGW  = $clog2(NDIG + 1);
  localparam int LENW  = $clog2(NDIG + 2);
  localparam int STEPS = MAGW / 2;
  localparam int STW   = $clog2(STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic [NDIG*4-1:0] bcd_r, bcd_nxt;
  logic [MAGW-1:0]   sh_r, sh_nxt;
  logic              neg_r, neg_nxt;
  logic [DIGW-1:0]   ndig_r, ndig_nxt;
  logic [STW-1:0]    step_r, step_nxt;
  logic [DIGW-1:0]   pos_r, pos_nxt;
  logic [LENW-1:0]   len_r, len_nxt;
  logic              sign_pend_r, sign_pend_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  logic [5:0]        out_character_r, out_character_nxt;
  logic [3:0]        out_text_length_r, out_text_length_nxt;
  logic              out_last_r, out_last_nxt;

  logic [NDIG*4-1:0] bcd_step;
  logic [MAGW-1:0]   sh_step;
  logic              nz;
  logic [DIGW-1:0]   ndig_inc, ndig_fin;
  logic [3:0]        cur_dig;
  logic              emit_last;
  logic              load;

  // Two dabble steps; a shift by two bits can add at most one significant digit,
  // so the digit count is tracked by checking the digit just above the current top.
  always_comb begin
    bcd_step = bcd_r;
    sh_step  = sh_r;
    for (int k = 0; k < 2; k++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_step[d*4 +: 4] >= sbda_pkg::BCD_ADJ_MIN) begin
          bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + sbda_pkg::BCD_ADJ;
        end
      end
      bcd_step = {bcd_step[NDIG*4-2:0], sh_step[MAGW-1]};
      sh_step  = {sh_step[MAGW-2:0], 1'b0};
    end
    nz = 1'b0;
    for (int d = 0; d < NDIG; d++) begin
      if (DIGW'(d) == ndig_r) begin
        nz = (bcd_step[d*4 +: 4] != 4'd0);
      end
    end
    ndig_inc = ndig_r + DIGW'(nz);
    ndig_fin = (ndig_inc == '0) ? DIGW'(1) : ndig_inc;
    cur_dig  = 4'd0;
    for (int d = 0; d < NDIG; d++) begin
      if (DIGW'(d) == pos_r) begin
        cur_dig = bcd_r[d*4 +: 4];
      end
    end
  end

  always_comb begin
    emit_last = !sign_pend_r && (pos_r == '0);
    load      = !stat.empty &&
                ((state_r == ST_IDLE) || ((state_r == ST_EMIT) && emit_last));
    pop       = load;

    state_nxt           = state_r;
    bcd_nxt             = bcd_r;
    sh_nxt              = sh_r;
    neg_nxt             = neg_r;
    ndig_nxt            = ndig_r;
    step_nxt            = step_r;
    pos_nxt             = pos_r;
    len_nxt             = len_r;
    sign_pend_nxt       = sign_pend_r;
    out_strobe_nxt      = 1'b0;
    out_character_nxt   = out_character_r;
    out_text_length_nxt = out_text_length_r;
    out_last_nxt        = 1'b0;

    case (state_r)
      ST_IDLE: begin
      end
      ST_CONV: begin
        bcd_nxt  = bcd_step;
        sh_nxt   = sh_step;
        ndig_nxt = ndig_inc;
        step_nxt = step_r - STW'(1);
        if (step_r == '0) begin
          state_nxt     = ST_EMIT;
          pos_nxt       = ndig_fin - DIGW'(1);
          len_nxt       = LENW'(ndig_fin) + LENW'(neg_r);
          sign_pend_nxt = neg_r;
        end
      end
      ST_EMIT: begin
        out_strobe_nxt      = 1'b1;
        out_text_length_nxt = 4'(len_r);
        out_last_nxt        = emit_last;
        if (sign_pend_r) begin
          out_character_nxt = sbda_pkg::CHAR_MINUS;
          sign_pend_nxt     = 1'b0;
        end else begin
          out_character_nxt = sbda_pkg::CHAR_ZERO + {2'b00, cur_dig};
          pos_nxt           = pos_r - DIGW'(1);
        end
        if (emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (load) begin
      state_nxt = ST_CONV;
      bcd_nxt   = '0;
      sh_nxt    = q_mag;
      neg_nxt   = q_neg;
      ndig_nxt  = '0;
      step_nxt  = STW'(STEPS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    bcd_r             <= bcd_nxt;
    sh_r              <= sh_nxt;
    neg_r             <= neg_nxt;
    ndig_r            <= ndig_nxt;
    step_r            <= step_nxt;
    pos_r             <= pos_nxt;
    len_r             <= len_nxt;
    sign_pend_r       <= sign_pend_nxt;
    out_character_r   <= out_character_nxt;
    out_text_length_r <= out_text_length_nxt;
    out_last_r        <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_character   = out_character_r;
  assign out_text_length = out_text_length_r;
  assign out_last        = out_last_r;

  `SBDA_ASSERT_NEXT(a_quiet_conv, clk, rst_n, state_r == ST_CONV, !out_strobe_r,
                    "character emitted during conversion")
  `SBDA_ASSERT_NOW(a_pop_not_conv, clk, rst_n, pop, state_r != ST_CONV,
                   "queue popped while a conversion runs")
  `SBDA_ASSERT_NOW(a_emit_len, clk, rst_n, state_r == ST_EMIT, len_r != '0,
                   "emitting a text of zero length")

endmodule
